// ===== sv/sub_pkg.sv =====
package sub_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 8;
	localparam int CMD_W = 2;
	localparam int COUNT_OUT_W = 7;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] count_t;

	// shift control broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} shift_t;

endpackage

// ===== sv/sub_cell.sv =====
module sub_cell
	import sub_pkg::*;
(
	input  logic   clk,
	input  shift_t ctl,
	input  key_t   key,
	input  logic   occupied,
	input  logic   left_below,
	input  key_t   left_key,
	input  key_t   right_key,
	output logic   below,
	output logic   match,
	output key_t   held_key
);

	key_t key_q;

	assign below    = occupied && (key_q < key);
	assign match    = occupied && (key_q == key);
	assign held_key = key_q;

	// On add or remove, cells below the sorted position keep their key; the rest shift.
	always_ff @(posedge clk) begin
		if (ctl.ins && !below) begin
			key_q <= left_below ? key : left_key;
		end else if (ctl.del && !below) begin
			key_q <= right_key;
		end
	end

endmodule

// ===== sv/sorted_unique_byte_set.sv =====
// Sorted set of up to CAPACITY distinct signed byte keys.
// Input channel (in_valid/in_ready): command (add, remove, search) and key.
// Output channel (out_valid/out_ready): success, full_reject, entry_count,
// is_empty, exactly one result transaction per input transaction.
// Every cell compares its key against the request in parallel and shifts
// toward its neighbor on add or remove, so a whole operation finishes in
// the cycle the input is accepted.
// The result is registered: out_valid rises in the cycle after input acceptance.
// Throughput: one transaction per cycle while the receiver takes results;
// the single result register accepts a new input in the same cycle its
// held result is taken.
// When the receiver stalls, the result is held and in_ready drops until
// the result is taken.
// Reset clears the count (empty set) and the output valid; key storage is
// not cleared, since only entries below the count are ever used.
module sorted_unique_byte_set
	import sub_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CMD_W-1:0]       command,
	input  logic signed [KEY_W-1:0] key,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   success,
	output logic                   full_reject,
	output logic [COUNT_OUT_W-1:0] entry_count,
	output logic                   is_empty
);

	count_t count_q;
	logic   out_valid_q;
	logic   success_q;
	logic   full_reject_q;
	logic [COUNT_OUT_W-1:0] entry_count_q;
	logic   is_empty_q;

	logic [CAPACITY-1:0] below;
	logic [CAPACITY-1:0] match;
	key_t                cell_key [CAPACITY];

	logic   accept;
	logic   found;
	logic   is_full;
	logic   do_add;
	logic   do_remove;
	shift_t ctl;
	count_t count_next;
	logic   ok;
	logic   full_hit;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign found    = |match;
	assign is_full  = (count_q == count_t'(CAPACITY));

	assign do_add    = (command == CMD_ADD) && !found && !is_full;
	assign do_remove = (command == CMD_REMOVE) && found;

	assign ctl.ins = accept && do_add;
	assign ctl.del = accept && do_remove;

	always_comb begin
		count_next = count_q;
		ok         = 1'b0;
		full_hit   = 1'b0;
		case (command)
			CMD_ADD: begin
				if (!found && is_full) begin
					full_hit = 1'b1;
				end else if (!found) begin
					count_next = count_q + count_t'(1);
					ok         = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					count_next = count_q - count_t'(1);
					ok         = 1'b1;
				end
			end
			CMD_SEARCH: begin
				ok = found;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic occupied;
		logic left_below;
		key_t left_key;
		key_t right_key;

		assign occupied = (count_q > count_t'(i));

		if (i == 0) begin : g_first
			assign left_below = 1'b1;
			assign left_key   = key;
		end else begin : g_mid
			assign left_below = below[i-1];
			assign left_key   = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key = key;
		end else begin : g_inner
			assign right_key = cell_key[i+1];
		end

		sub_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key        (key),
			.occupied   (occupied),
			.left_below (left_below),
			.left_key   (left_key),
			.right_key  (right_key),
			.below      (below[i]),
			.match      (match[i]),
			.held_key   (cell_key[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			success_q     <= ok;
			full_reject_q <= full_hit;
			entry_count_q <= COUNT_OUT_W'(count_next);
			is_empty_q    <= (count_next == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign full_reject = full_reject_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

endmodule
